// ===== hw/rtl/vlm_pkg.sv =====
// Shared types and constants of the vibration level monitor.
package vlm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = SAMPLE_W + 1;
  localparam int unsigned LEVEL_W  = 18;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned REG_IDX_W = 1;

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam int unsigned LEVEL_DIV = 200;
  // 200 = 25 << 3: shift out the power of two, multiply by a reciprocal for the rest
  localparam int unsigned DIV_SHIFT = 3;
  localparam int unsigned DIV_ODD   = LEVEL_DIV >> DIV_SHIFT;

  typedef logic [KIND_W-1:0]           kind_t;
  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic [LEVEL_W-1:0]          level_t;
  typedef logic [DUTY_W-1:0]           duty_t;
  typedef logic [REG_IDX_W-1:0]        reg_idx_t;

  localparam level_t LEVEL_MAX = '1;

  localparam kind_t KIND_SAMPLE = 2'd0;
  localparam kind_t KIND_REPORT = 2'd1;
  localparam kind_t KIND_OFF    = 2'd2;

  localparam reg_idx_t REG_WARNING = 1'b0;
  localparam reg_idx_t REG_DANGER  = 1'b1;

  localparam duty_t DUTY_OFF    = 7'd0;
  localparam duty_t DUTY_WARN   = 7'd50;
  localparam duty_t DUTY_DANGER = 7'd90;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_REPORT,
    OP_OFF,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e     op;
    sample_t x;
    sample_t y;
    sample_t z;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ROOT_GO,
    ST_ROOT,
    ST_DIV,
    ST_FIN
  } st_e;

endpackage

// ===== hw/rtl/vlm_front.sv =====
// Front end: input beat acceptance, kind decode and a short item queue.
module vlm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vlm_pkg::kind_t   kind_i,
  input  vlm_pkg::sample_t sample_x_i,
  input  vlm_pkg::sample_t sample_y_i,
  input  vlm_pkg::sample_t sample_z_i,
  output logic             q_valid_o,
  output vlm_pkg::item_t   q_item_o,
  input  logic             q_pop_i
);
  import vlm_pkg::*;

  item_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              full;
  logic              push;
  item_t             new_item;

  always_comb begin
    new_item.x = sample_x_i;
    new_item.y = sample_y_i;
    new_item.z = sample_z_i;
    unique case (kind_i)
      KIND_SAMPLE: new_item.op = OP_SAMPLE;
      KIND_REPORT: new_item.op = OP_REPORT;
      KIND_OFF:    new_item.op = OP_OFF;
      default:     new_item.op = OP_NONE;
    endcase
  end

  assign full       = (cnt_q == QCNT_W'(QDEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== hw/rtl/vlm_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
module vlm_sqrt #(
  parameter int unsigned RT_W = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2*RT_W-1:0] rad_i,
  output logic              done_o,
  output logic [RT_W-1:0]   root_o
);
  import vlm_pkg::*;

  localparam int unsigned RAD_W = 2 * RT_W;
  localparam int unsigned REM_W = RT_W + 3;
  localparam int unsigned CNT_W = $clog2(RT_W);

  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q;
  logic [RT_W-1:0]  root_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign fits   = (rem_sh >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CNT_W'(RT_W - 1);
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RT_W-2:0], fits};
      cnt_q  <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/vlm_back.sv =====
// Back end: accumulators, report sequencer, divide by 200, duty and result register.
module vlm_back #(
  parameter int unsigned ACC_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  vlm_pkg::item_t              q_item_i,
  output logic                        q_pop_o,
  input  logic                        cfg_we_i,
  input  vlm_pkg::reg_idx_t           cfg_idx_i,
  input  vlm_pkg::level_t             cfg_data_i,
  output logic                        sqrt_start_o,
  output logic [2*ACC_WIDTH+1:0]      sqrt_rad_o,
  input  logic                        sqrt_done_i,
  input  logic [ACC_WIDTH:0]          sqrt_root_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output vlm_pkg::level_t             level_o,
  output vlm_pkg::duty_t              duty_o,
  output logic                        reported_o
);
  import vlm_pkg::*;

  localparam int unsigned RT_W  = ACC_WIDTH + 1;
  localparam int unsigned SQ_W  = 2 * RT_W;
  localparam int unsigned PR_W  = 2 * ACC_WIDTH;
  localparam int unsigned DT_W  = RT_W - DIV_SHIFT;
  localparam int unsigned DK    = DT_W + $clog2(DIV_ODD);
  localparam int unsigned DM_W  = DT_W + 1;
  localparam int unsigned DP_W  = DT_W + DM_W;
  // ceil(2^DK / 25): exact floor quotient for every DT_W-bit dividend
  localparam logic [DM_W-1:0] DIV_MAGIC =
    DM_W'(((64'd1 << DK) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
  localparam logic [1:0]  AX_LAST = 2'd2;

  typedef logic [ACC_WIDTH-1:0] acc_t;

  function automatic acc_t sat_add(acc_t sum, sample_t s);
    logic [MAG_W-1:0]     mag;
    logic [ACC_WIDTH:0]   wide;
    mag  = s[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(s)) : MAG_W'(s);
    wide = {1'b0, sum} + (ACC_WIDTH+1)'(mag);
    return wide[ACC_WIDTH] ? '1 : wide[ACC_WIDTH-1:0];
  endfunction

  st_e              state_q, state_d;
  acc_t             sum_x_q, sum_y_q, sum_z_q;
  duty_t            duty_q;
  level_t           warn_q, danger_q;
  logic             out_valid_q;
  level_t           level_q;
  duty_t            duty_out_q;
  logic             reported_q;
  logic [1:0]       ax_q;
  logic [PR_W-1:0]  prod_q;
  logic [SQ_W-1:0]  sq_q;
  logic [RT_W-1:0]  div_q;
  logic [DP_W-1:0]  dprod_q;

  logic             out_free;
  logic             q_pop;
  logic             fin_load;
  acc_t             mul_a;
  logic [DT_W-1:0]  div_in;
  level_t           level_sat;
  duty_t            duty_rep;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (q_pop && q_item_i.op == OP_REPORT) state_d = ST_MUL;
      ST_MUL:     state_d = ST_ADD;
      ST_ADD:     state_d = (ax_q == AX_LAST) ? ST_ROOT_GO : ST_MUL;
      ST_ROOT_GO: state_d = ST_ROOT;
      ST_ROOT:    if (sqrt_done_i) state_d = ST_DIV;
      ST_DIV:     state_d = ST_FIN;
      ST_FIN:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop        = 1'b0;
    sqrt_start_o = 1'b0;
    fin_load     = 1'b0;
    unique case (state_q)
      ST_IDLE:    q_pop        = q_valid_i && out_free;
      ST_ROOT_GO: sqrt_start_o = 1'b1;
      ST_FIN:     fin_load     = out_free;
      default:    ;
    endcase
  end

  assign q_pop_o    = q_pop;
  assign sqrt_rad_o = sq_q;

  always_comb begin
    case (ax_q)
      2'd0:    mul_a = sum_x_q;
      2'd1:    mul_a = sum_y_q;
      default: mul_a = sum_z_q;
    endcase
  end

  // divide by 200: drop the low three root bits, then multiply by the reciprocal of 25
  assign div_in = sqrt_root_i[RT_W-1:DIV_SHIFT];

  assign level_sat = (div_q > RT_W'(LEVEL_MAX)) ? LEVEL_MAX : div_q[LEVEL_W-1:0];

  always_comb begin
    if (level_sat >= danger_q) begin
      duty_rep = DUTY_DANGER;
    end else if (level_sat >= warn_q) begin
      duty_rep = DUTY_WARN;
    end else begin
      duty_rep = duty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      duty_q      <= DUTY_OFF;
      warn_q      <= '0;
      danger_q    <= LEVEL_MAX;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WARNING: warn_q   <= cfg_data_i;
          REG_DANGER:  danger_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (q_pop) begin
        case (q_item_i.op)
          OP_SAMPLE: begin
            sum_x_q <= sat_add(sum_x_q, q_item_i.x);
            sum_y_q <= sat_add(sum_y_q, q_item_i.y);
            sum_z_q <= sat_add(sum_z_q, q_item_i.z);
          end
          OP_OFF: begin
            sum_x_q <= '0;
            sum_y_q <= '0;
            sum_z_q <= '0;
            duty_q  <= DUTY_OFF;
          end
          default: ;
        endcase
      end
      if (fin_load) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        duty_q  <= duty_rep;
      end
      if ((q_pop && q_item_i.op != OP_REPORT) || fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop) begin
      ax_q       <= '0;
      sq_q       <= '0;
      level_q    <= '0;
      reported_q <= 1'b0;
      duty_out_q <= (q_item_i.op == OP_OFF) ? DUTY_OFF : duty_q;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_a * mul_a;
    end
    if (state_q == ST_ADD) begin
      sq_q <= sq_q + SQ_W'(prod_q);
      ax_q <= ax_q + 1'b1;
    end
    if (state_q == ST_ROOT && sqrt_done_i) begin
      dprod_q <= DP_W'(div_in) * DP_W'(DIV_MAGIC);
    end
    if (state_q == ST_DIV) begin
      div_q <= RT_W'(dprod_q[DP_W-1:DK]);
    end
    if (fin_load) begin
      level_q    <= level_sat;
      duty_out_q <= duty_rep;
      reported_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign duty_o      = duty_out_q;
  assign reported_o  = reported_q;

`ifndef NO_ASSERTIONS
  a_duty_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q == DUTY_OFF || duty_q == DUTY_WARN || duty_q == DUTY_DANGER)
    else $error("duty register holds an unknown value");

  a_pop_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (!out_valid_q || !out_stall_i))
    else $error("item taken while a stalled result is held");

  a_root_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done_i |-> state_q == ST_ROOT)
    else $error("root finished outside the wait state");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> (sum_x_q == '0 && sum_y_q == '0 && sum_z_q == '0 && reported_q))
    else $error("report did not clear the accumulators");
`endif

endmodule

// ===== hw/rtl/vibration_level_monitor.sv =====
// Top level of the vibration level monitor.
//
// Input channel (in_valid_i / in_stall_o): one beat carries kind_i and the three
// axis samples. Kind sample adds |x|, |y|, |z| into saturating accumulators of
// ACC_WIDTH bits; kind report forms floor(isqrt(x^2+y^2+z^2)/200), saturated to
// 18 bits, sets the duty and clears the sums; kind power-off clears the sums and
// the duty; kind 3 leaves all state alone.
// Output channel (out_valid_o / out_stall_i): exactly one result beat per input
// beat, in order, carrying level_o, duty_o and reported_o.
// Config port: cfg_we_i writes cfg_data_i into warning (index 0) or danger
// (index 1) threshold; write only while the block is idle.
// Sample, power-off and kind 3 items go from the queue straight into the result register,
// one beat a cycle while no report runs and the receiver does not stall. A report leaves
// the queue, forms the squares axis by axis through one ACC_WIDTH x ACC_WIDTH multiplier,
// starts the bit-serial root, does the reciprocal divide by 200 and loads the result
// register; the sequencer takes the next item only once the report has been loaded.
// A two-beat queue sits in front of the sequencer, so inputs keep landing while
// a report runs or a result waits; when the receiver stalls the result register
// holds and the queue fills, then in_stall_o rises.
// Reset clears sums, duty, thresholds (warning 0, danger all ones) and queue.
module vibration_level_monitor #(
  parameter int unsigned ACC_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vlm_pkg::kind_t    kind_i,
  input  vlm_pkg::sample_t  sample_x_i,
  input  vlm_pkg::sample_t  sample_y_i,
  input  vlm_pkg::sample_t  sample_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vlm_pkg::level_t   level_o,
  output vlm_pkg::duty_t    duty_o,
  output logic              reported_o,
  input  logic              cfg_we_i,
  input  vlm_pkg::reg_idx_t cfg_idx_i,
  input  vlm_pkg::level_t   cfg_data_i
);
  import vlm_pkg::*;

  localparam int unsigned RT_W = ACC_WIDTH + 1;

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              sqrt_start;
  logic [2*RT_W-1:0] sqrt_rad;
  logic              sqrt_done;
  logic [RT_W-1:0]   sqrt_root;

  // accepts beats and buffers decoded items
  vlm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .sample_z_i (sample_z_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // root unit, driven by the report sequence
  vlm_sqrt #(
    .RT_W (RT_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // executes items and owns the result register
  vlm_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sqrt_start_o (sqrt_start),
    .sqrt_rad_o   (sqrt_rad),
    .sqrt_done_i  (sqrt_done),
    .sqrt_root_i  (sqrt_root),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .level_o      (level_o),
    .duty_o       (duty_o),
    .reported_o   (reported_o)
  );

endmodule

// ===== test/vlm_checker.sv =====
// Scoreboard for the vibration level monitor: tracks sums, duty and thresholds, checks results.
module vlm_checker #(
  parameter int unsigned ACC_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  vlm_pkg::kind_t    kind_i,
  input  vlm_pkg::sample_t  sample_x_i,
  input  vlm_pkg::sample_t  sample_y_i,
  input  vlm_pkg::sample_t  sample_z_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  vlm_pkg::level_t   level_i,
  input  vlm_pkg::duty_t    duty_i,
  input  logic              reported_i,
  input  logic              cfg_we_i,
  input  vlm_pkg::reg_idx_t cfg_idx_i,
  input  vlm_pkg::level_t   cfg_data_i,
  output int unsigned       mismatches_o,
  output int unsigned       backlog_o
);
  import vlm_pkg::*;

  typedef struct {
    level_t level;
    duty_t  duty;
    logic   reported;
  } reading_t;

  localparam logic [63:0] SUM_MAX = (64'd1 << ACC_WIDTH) - 64'd1;

  logic [63:0] sum_x, sum_y, sum_z;
  duty_t       duty_now;
  level_t      warn_at, danger_at;
  reading_t    due_readings[$];
  int unsigned mismatches = 0;
  int unsigned backlog = 0;

  assign mismatches_o = mismatches;
  assign backlog_o    = backlog;

  // saturating add of |s|; the most negative sample counts 32768
  function automatic logic [63:0] add_magnitude(logic [63:0] sum, sample_t s);
    logic [63:0] mag;
    mag = (s < 0) ? 64'(-int'(s)) : 64'(int'(s));
    return (sum + mag > SUM_MAX) ? SUM_MAX : sum + mag;
  endfunction

  function automatic logic [67:0] root_floor(logic [67:0] v);
    logic [67:0] r, c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (68'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic level_t level_of(logic [63:0] sx, logic [63:0] sy, logic [63:0] sz);
    logic [67:0] energy, lvl;
    energy = 68'(sx) * 68'(sx) + 68'(sy) * 68'(sy) + 68'(sz) * 68'(sz);
    lvl = root_floor(energy) / 68'(LEVEL_DIV);
    return (lvl > 68'(LEVEL_MAX)) ? LEVEL_MAX : level_t'(lvl);
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic take_beat(kind_t kind, sample_t x, sample_t y, sample_t z);
    reading_t r;
    r.level    = '0;
    r.reported = 1'b0;
    case (kind)
      KIND_SAMPLE: begin
        sum_x = add_magnitude(sum_x, x);
        sum_y = add_magnitude(sum_y, y);
        sum_z = add_magnitude(sum_z, z);
      end
      KIND_REPORT: begin
        r.level = level_of(sum_x, sum_y, sum_z);
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        // danger takes precedence when both thresholds are met
        if (r.level >= danger_at) duty_now = DUTY_DANGER;
        else if (r.level >= warn_at) duty_now = DUTY_WARN;
        r.reported = 1'b1;
      end
      KIND_OFF: begin
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        duty_now = DUTY_OFF;
      end
      default: ;  // spare code leaves everything alone
    endcase
    r.duty = duty_now;
    due_readings.push_back(r);
  endtask

  task automatic check_reading(level_t level, duty_t duty, logic reported);
    reading_t want;
    if (due_readings.size() == 0) begin
      report_mismatch($sformatf("unexpected beat: level %0d duty %0d reported %0b",
                                level, duty, reported));
      return;
    end
    want = due_readings.pop_front();
    if (level !== want.level)
      report_mismatch($sformatf("level %0d, expected %0d", level, want.level));
    if (duty !== want.duty)
      report_mismatch($sformatf("duty %0d, expected %0d", duty, want.duty));
    if (reported !== want.reported)
      report_mismatch($sformatf("reported %0b, expected %0b", reported, want.reported));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sum_x     = '0;
      sum_y     = '0;
      sum_z     = '0;
      duty_now  = DUTY_OFF;
      warn_at   = '0;
      danger_at = LEVEL_MAX;
      due_readings.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WARNING: warn_at = cfg_data_i;
          REG_DANGER:  danger_at = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        take_beat(kind_i, sample_x_i, sample_y_i, sample_z_i);
      if (out_valid_i && !out_stall_i)
        check_reading(level_i, duty_i, reported_i);
    end
    backlog = due_readings.size();
  end

endmodule

// ===== test/tb_vibration_level_monitor.sv =====
// Testbench top for the vibration level monitor: stimulus, receiver stalls, watchdog, verdict.
module tb_vibration_level_monitor;
  import vlm_pkg::*;

  localparam int unsigned ACC_W         = 24;
  localparam int unsigned RESET_CYCLES  = 12;
  // long enough for a report to run, with a margin on top
  localparam int unsigned SETTLE_CYCLES = 2 * ACC_W + 40;
  // longest hold-off by the receiver, used once to back the block up
  localparam int unsigned HOLD_CYCLES   = 400;
  // cycles without any beat on either channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned PHASE_BEATS   = 40;
  // enough near-full-scale samples to drive every sum into saturation
  localparam int unsigned CEILING_BEATS = 540;

  // kind 3 has no name of its own in the package; it is the spare operation
  localparam kind_t KIND_SPARE = kind_t'(OP_NONE);

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  kind_t    kind_i      = KIND_SAMPLE;
  sample_t  sample_x_i  = '0;
  sample_t  sample_y_i  = '0;
  sample_t  sample_z_i  = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  level_t   level_o;
  duty_t    duty_o;
  logic     reported_o;
  logic     cfg_we_i    = 1'b0;
  reg_idx_t cfg_idx_i   = REG_WARNING;
  level_t   cfg_data_i  = '0;

  int unsigned mismatches, backlog;
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned holds_asked = 0, holds_done = 0;
  int unsigned quiet_cycles = 0;

  vibration_level_monitor #(
    .ACC_WIDTH(ACC_W)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .sample_x_i,
    .sample_y_i,
    .sample_z_i,
    .out_valid_o,
    .out_stall_i,
    .level_o,
    .duty_o,
    .reported_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  vlm_checker #(
    .ACC_WIDTH(ACC_W)
  ) checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i   (in_stall_o),
    .kind_i,
    .sample_x_i,
    .sample_y_i,
    .sample_z_i,
    .out_valid_i  (out_valid_o),
    .out_stall_i,
    .level_i      (level_o),
    .duty_i       (duty_o),
    .reported_i   (reported_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .mismatches_o (mismatches),
    .backlog_o    (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls at stall_pct, or one long hold-off on request so
  // that the result register and the input queue fill and in_stall_o rises.
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog. Channels are looked at on the falling edge, where every input
  // and output has settled for the coming rising edge.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Sample value for one axis. Loud values sit close to full scale, of either
  // sign, and are used to push the sums into saturation quickly.
  function automatic sample_t axis_value(bit loud);
    int v;
    if (loud) begin
      v = int'($urandom_range(31500, 32768));
      if ($urandom_range(1)) v = -v;
      else if (v > 32767) v = 32767;
    end else begin
      case ($urandom_range(9))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = 0;
        3:       v = -1;
        4, 5:    v = int'($urandom_range(0, 511)) - 256;
        default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
    end
    return sample_t'(v);
  endfunction

  // Offer one beat, after a random gap at idle_pct, and return on the edge
  // that takes it. Stall is looked at on the falling edge before that edge.
  // Valid stays high on return, so back-to-back beats need no second write.
  task automatic send_beat(kind_t kind, sample_t x, sample_t y, sample_t z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    sample_x_i <= x;
    sample_y_i <= y;
    sample_z_i <= z;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every result, then let a report that might still
  // be running finish before touching the thresholds.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both thresholds, one after the other; the write enable stays high across.
  task automatic set_thresholds(level_t warn, level_t danger);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WARNING;
    cfg_data_i <= warn;
    @(posedge clk_i);
    cfg_idx_i  <= REG_DANGER;
    cfg_data_i <= danger;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly bursts of samples closed by a report, with power-off beats, spare
  // kinds and reports on empty sums mixed in. Spare kinds are not counted.
  task automatic run_sequences(int unsigned beats);
    int unsigned sent, pick, n;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        n = $urandom_range(1, 10);
        repeat (n) send_beat(KIND_SAMPLE, axis_value(0), axis_value(0), axis_value(0));
        send_beat(KIND_REPORT, axis_value(0), axis_value(0), axis_value(0));
        sent += n + 1;
      end else if (pick < 88) begin
        send_beat(KIND_OFF, axis_value(0), axis_value(0), axis_value(0));
        sent++;
      end else if (pick < 94) begin
        send_beat(KIND_SPARE, axis_value(0), axis_value(0), axis_value(0));
      end else begin
        send_beat(KIND_REPORT, axis_value(0), axis_value(0), axis_value(0));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned warn;
    int unsigned danger;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats, warning at 200 and danger at 400
    set_thresholds(18'd200, 18'd400);
    send_beat(KIND_REPORT, 16'sh0000, 16'sh0000, 16'sh0000);  // empty sums, level 0
    send_beat(KIND_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh0000);  // most negative counts 32768
    send_beat(KIND_SAMPLE, 16'shffff, 16'sh0001, 16'sh8000);
    send_beat(KIND_REPORT, 16'sh1234, 16'sh5678, 16'sh7abc);  // about 283: warning
    send_beat(KIND_SPARE,  16'sh8000, 16'sh7fff, 16'shffff);  // nothing moves
    send_beat(KIND_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
    send_beat(KIND_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
    send_beat(KIND_REPORT, 16'sh0000, 16'sh0000, 16'sh0000);  // above both: danger wins
    send_beat(KIND_SPARE,  16'sh0000, 16'sh0000, 16'sh0000);
    send_beat(KIND_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh3039);
    send_beat(KIND_OFF,    16'sh7fff, 16'sh8000, 16'sh3039);  // clears sums and duty
    send_beat(KIND_REPORT, 16'sh0000, 16'sh0000, 16'sh0000);  // below warning, duty held
    send_beat(KIND_SAMPLE, 16'sh5555, 16'shaaaa, 16'sh7fff);
    send_beat(KIND_SAMPLE, 16'shaaaa, 16'sh5555, 16'sh8001);
    send_beat(KIND_REPORT, 16'shffff, 16'shffff, 16'shffff);
    send_beat(KIND_SPARE,  16'shffff, 16'shffff, 16'shffff);
    send_beat(KIND_SAMPLE, 16'sh0001, 16'shffff, 16'sh0000);
    send_beat(KIND_OFF,    16'sh0000, 16'sh0000, 16'sh0000);
    settle();

    // Random phases, each with its own thresholds and idling pattern
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin  // extremes: every report reaches warning, none danger
          set_thresholds('0, LEVEL_MAX);
          idle_pct = 0;  stall_pct = 0;
        end
        1: begin  // nothing reachable, duty only moves on power-off
          set_thresholds(LEVEL_MAX, LEVEL_MAX);
          idle_pct = 48; stall_pct = 0;
        end
        2: begin  // every report is danger; long hold-off backs the block up
          set_thresholds('0, '0);
          idle_pct = 0;  stall_pct = 48;
          holds_asked++;
        end
        3: begin
          warn   = $urandom_range(100, 900);
          danger = warn + $urandom_range(0, 1500);
          set_thresholds(level_t'(warn), level_t'(danger));
          idle_pct = 20; stall_pct = 20;
        end
        default: begin  // danger may fall below warning here
          warn   = $urandom_range(0, 600);
          danger = $urandom_range(0, 1200);
          set_thresholds(level_t'(warn), level_t'(danger));
          idle_pct = 0;  stall_pct = 0;
        end
      endcase
      run_sequences(PHASE_BEATS);
      settle();
    end

    // Saturation: all three sums pinned at the top, level at the largest the sums give
    set_thresholds(18'd2000, 18'd140000);
    idle_pct = 20; stall_pct = 20;
    repeat (CEILING_BEATS) send_beat(KIND_SAMPLE, axis_value(1), axis_value(1), axis_value(1));
    send_beat(KIND_REPORT, axis_value(0), axis_value(0), axis_value(0));
    run_sequences(20);
    settle();

    if (mismatches == 0 && backlog == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
